[design/hbm_pkg.sv]
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor package
// Sizes, input kind codes and result event codes shared by the monitor and bench.
// ----------------------------------------------------------------------------
package hbm_pkg;

  localparam int MaxEntries = 16;
  localparam int MaxResults = 16;
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int ResW       = $clog2(MaxResults + 1);

  localparam logic [15:0] ThresholdReset = 16'd100;

  localparam logic [1:0] KindTick     = 2'd0;
  localparam logic [1:0] KindRegister = 2'd1;
  localparam logic [1:0] KindUnreg    = 2'd2;
  localparam logic [1:0] KindHeard    = 2'd3;

  localparam logic [2:0] EvExpired    = 3'd0;
  localparam logic [2:0] EvRegistered = 3'd1;
  localparam logic [2:0] EvFull       = 3'd2;
  localparam logic [2:0] EvUnreg      = 3'd3;
  localparam logic [2:0] EvNotFound   = 3'd4;
  localparam logic [2:0] EvReset      = 3'd5;

  localparam logic CfgIdxEnable    = 1'b0;
  localparam logic CfgIdxThreshold = 1'b1;

endpackage

[design/heartbeat_timeout_monitor.sv]
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor
// Table of watched module ids with saturating silence counters, walked one
// entry per cycle by a small sequencer around a single increment/compare unit.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. Register never raises
// busy_o. An enabled tick walks the table one entry per cycle through the shared
// counter unit and keeps busy_o high until it is past the last entry. Heard and
// unregister search one entry per cycle; unregister then moves each later entry
// down one per cycle through the same read port, and busy_o stays high through
// search and move. Every result word is on the outputs for exactly one cycle
// with valid_o high; the receiver cannot stall, and last_o marks the final
// result of a word.
module heartbeat_timeout_monitor
  import hbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  kind_i,
  input  logic [15:0] module_id_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        valid_o,
  output logic [2:0]  event_res_o,
  output logic [15:0] module_id_out_o,
  output logic [15:0] silence_ticks_o,
  output logic        last_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StTick  = 2'd1;
  localparam logic [1:0] StFind  = 2'd2;
  localparam logic [1:0] StShift = 2'd3;

  logic [15:0] ids_q [MaxEntries];
  logic [15:0] cnts_q [MaxEntries];

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic [1:0]      kind_q, kind_d;
  logic [15:0]     key_q, key_d;
  logic [15:0]     held_q, held_d;
  logic            enable_q;
  logic [15:0]     thr_q;

  logic            pend_vld_q, pend_vld_d;
  logic [15:0]     pend_id_q, pend_id_d;
  logic [15:0]     pend_cnt_q, pend_cnt_d;
  logic [ResW-1:0] nres_q, nres_d;

  logic            out_vld_q, out_vld_d;
  logic [2:0]      out_ev_q, out_ev_d;
  logic [15:0]     out_id_q, out_id_d;
  logic [15:0]     out_cnt_q, out_cnt_d;
  logic            out_last_q, out_last_d;

  logic            we_id, we_cnt;
  logic [IdxW-1:0] wr_addr;
  logic [15:0]     wr_id, wr_cnt;
  logic [CntW-1:0] idx_nx;
  logic [IdxW-1:0] rd_addr;
  logic [15:0]     rd_id, rd_cnt, inc_cnt;
  logic            accept;

  assign accept  = start_i && (state_q == StIdle);
  assign idx_nx  = idx_q + CntW'(1);
  assign rd_addr = (state_q == StShift) ? idx_nx[IdxW-1:0] : idx_q[IdxW-1:0];
  assign rd_id   = ids_q[rd_addr];
  assign rd_cnt  = cnts_q[rd_addr];
  assign inc_cnt = (rd_cnt == 16'hFFFF) ? rd_cnt : rd_cnt + 16'd1;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    kind_d     = kind_q;
    key_d      = key_q;
    held_d     = held_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    pend_cnt_d = pend_cnt_q;
    nres_d     = nres_q;
    out_vld_d  = 1'b0;
    out_ev_d   = out_ev_q;
    out_id_d   = out_id_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;
    we_id      = 1'b0;
    we_cnt     = 1'b0;
    wr_addr    = idx_q[IdxW-1:0];
    wr_id      = rd_id;
    wr_cnt     = rd_cnt;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          kind_d = kind_i;
          key_d  = module_id_i;
          idx_d  = '0;
          unique case (kind_i)
            KindTick: begin
              if (enable_q) begin
                state_d    = StTick;
                pend_vld_d = 1'b0;
                nres_d     = '0;
              end
            end
            KindRegister: begin
              out_vld_d  = 1'b1;
              out_id_d   = module_id_i;
              out_cnt_d  = 16'd0;
              out_last_d = 1'b1;
              if (count_q >= CntW'(MaxEntries)) begin
                out_ev_d = EvFull;
              end else begin
                out_ev_d = EvRegistered;
                we_id    = 1'b1;
                we_cnt   = 1'b1;
                wr_addr  = count_q[IdxW-1:0];
                wr_id    = module_id_i;
                wr_cnt   = 16'd0;
                count_d  = count_q + CntW'(1);
              end
            end
            default: begin
              state_d = StFind;
            end
          endcase
        end
      end
      StTick: begin
        if (idx_q == count_q) begin
          state_d = StIdle;
          if (pend_vld_q) begin
            out_vld_d  = 1'b1;
            out_ev_d   = EvExpired;
            out_id_d   = pend_id_q;
            out_cnt_d  = pend_cnt_q;
            out_last_d = 1'b1;
          end
        end else begin
          we_cnt = 1'b1;
          wr_cnt = inc_cnt;
          idx_d  = idx_nx;
          if (inc_cnt >= thr_q && nres_q < ResW'(MaxResults)) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_ev_d   = EvExpired;
              out_id_d   = pend_id_q;
              out_cnt_d  = pend_cnt_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_id_d  = rd_id;
            pend_cnt_d = inc_cnt;
            nres_d     = nres_q + ResW'(1);
          end
        end
      end
      StFind: begin
        if (idx_q == count_q) begin
          state_d    = StIdle;
          out_vld_d  = 1'b1;
          out_ev_d   = EvNotFound;
          out_id_d   = key_q;
          out_cnt_d  = 16'd0;
          out_last_d = 1'b1;
        end else if (rd_id == key_q) begin
          if (kind_q == KindUnreg) begin
            state_d = StShift;
            held_d  = rd_cnt;
          end else begin
            state_d    = StIdle;
            we_cnt     = 1'b1;
            wr_cnt     = 16'd0;
            out_vld_d  = 1'b1;
            out_ev_d   = EvReset;
            out_id_d   = key_q;
            out_cnt_d  = 16'd0;
            out_last_d = 1'b1;
          end
        end else begin
          idx_d = idx_nx;
        end
      end
      StShift: begin
        if (idx_nx < count_q) begin
          we_id  = 1'b1;
          we_cnt = 1'b1;
          idx_d  = idx_nx;
        end else begin
          state_d    = StIdle;
          count_d    = count_q - CntW'(1);
          out_vld_d  = 1'b1;
          out_ev_d   = EvUnreg;
          out_id_d   = key_q;
          out_cnt_d  = held_q;
          out_last_d = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      nres_q     <= '0;
      out_vld_q  <= 1'b0;
      enable_q   <= 1'b1;
      thr_q      <= ThresholdReset;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      nres_q     <= nres_d;
      out_vld_q  <= out_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgIdxEnable:    enable_q <= cfg_data_i[0];
          CfgIdxThreshold: thr_q    <= cfg_data_i;
          default:         thr_q    <= thr_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    key_q      <= key_d;
    held_q     <= held_d;
    pend_id_q  <= pend_id_d;
    pend_cnt_q <= pend_cnt_d;
    out_ev_q   <= out_ev_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    if (we_id) begin
      ids_q[wr_addr] <= wr_id;
    end
    if (we_cnt) begin
      cnts_q[wr_addr] <= wr_cnt;
    end
  end

  assign busy_o          = (state_q != StIdle);
  assign valid_o         = out_vld_q;
  assign event_res_o     = out_ev_q;
  assign module_id_out_o = out_id_q;
  assign silence_ticks_o = out_cnt_q;
  assign last_o          = out_last_q;

`ifndef SYNTHESIS
  // The table never holds more entries than it has rows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries))
    else $error("entry count exceeds table size");

  // A result that is not the final one comes from a tick walk still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |-> busy_o)
    else $error("non-final result outside a tick walk");

  // The walk index never passes the entry count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTick || state_q == StFind) |-> (idx_q <= count_q))
    else $error("walk index beyond entry count");
`endif

endmodule

[sim/hbm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor checker
// Watches the word and result channels and the register port of the monitor,
// keeps its own copy of the watch table and settings, predicts the events of
// every accepted word and compares each result word with the oldest one.
// ----------------------------------------------------------------------------
module hbm_checker
  import hbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  kind_i,
  input  logic [15:0] module_id_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        valid_i,
  input  logic [2:0]  event_res_i,
  input  logic [15:0] module_id_out_i,
  input  logic [15:0] silence_ticks_i,
  input  logic        last_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] id;
    logic [15:0] ticks;
    logic        last;
  } hb_event_t;

  hb_event_t   pending_events[$];
  hb_event_t   oldest;
  logic [15:0] watch_ids[MaxEntries];
  logic [15:0] watch_counts[MaxEntries];
  int          watch_len;
  logic        mon_enable;
  logic [15:0] mon_threshold;
  int unsigned errors;

  task automatic post_event(input logic [2:0] ev, input logic [15:0] id,
                            input logic [15:0] ticks);
    pending_events.push_back('{ev: ev, id: id, ticks: ticks, last: 1'b1});
  endtask

  task automatic predict_events(input logic [1:0] kind, input logic [15:0] id);
    hb_event_t   expired[$];
    int          hit;
    logic [15:0] held;
    hit = watch_len;
    case (kind)
      KindTick: begin
        if (mon_enable) begin
          for (int i = 0; i < watch_len; i++) begin
            if (watch_counts[i] != 16'hFFFF) watch_counts[i] = watch_counts[i] + 16'd1;
            if (watch_counts[i] >= mon_threshold && expired.size() < MaxResults) begin
              expired.push_back('{ev: EvExpired, id: watch_ids[i],
                                  ticks: watch_counts[i], last: 1'b0});
            end
          end
          for (int j = 0; j < expired.size(); j++) begin
            if (j == expired.size() - 1) expired[j].last = 1'b1;
            pending_events.push_back(expired[j]);
          end
        end
      end
      KindRegister: begin
        if (watch_len >= MaxEntries) begin
          post_event(EvFull, id, 16'd0);
        end else begin
          watch_ids[watch_len] = id;
          watch_counts[watch_len] = 16'd0;
          watch_len++;
          post_event(EvRegistered, id, 16'd0);
        end
      end
      default: begin
        for (int i = watch_len - 1; i >= 0; i--) begin
          if (watch_ids[i] == id) hit = i;
        end
        if (hit >= watch_len) begin
          post_event(EvNotFound, id, 16'd0);
        end else if (kind == KindUnreg) begin
          held = watch_counts[hit];
          for (int i = hit; i + 1 < watch_len; i++) begin
            watch_ids[i] = watch_ids[i + 1];
            watch_counts[i] = watch_counts[i + 1];
          end
          watch_len--;
          post_event(EvUnreg, id, held);
        end else begin
          watch_counts[hit] = 16'd0;
          post_event(EvReset, id, 16'd0);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_events.delete();
      watch_len = 0;
      mon_enable = 1'b1;
      mon_threshold = ThresholdReset;
      errors = 0;
    end else begin
      if (valid_i) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result word: event_res %0d module_id_out %h",
                 event_res_i, module_id_out_i);
          errors++;
        end else begin
          oldest = pending_events.pop_front();
          if (event_res_i !== oldest.ev) begin
            $error("event_res: expected %0d, got %0d", oldest.ev, event_res_i);
            errors++;
          end
          if (module_id_out_i !== oldest.id) begin
            $error("module_id_out: expected %h, got %h", oldest.id, module_id_out_i);
            errors++;
          end
          if (silence_ticks_i !== oldest.ticks) begin
            $error("silence_ticks: expected %0d, got %0d", oldest.ticks, silence_ticks_i);
            errors++;
          end
          if (last_i !== oldest.last) begin
            $error("last: expected %0d, got %0d", oldest.last, last_i);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgIdxEnable) mon_enable = cfg_data_i[0];
        else mon_threshold = cfg_data_i;
      end
      if (start_i && !busy_i) predict_events(kind_i, module_id_i);
    end
    pending_o    <= pending_events.size();
    fail_count_o <= errors;
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heartbeat timeout monitor testbench
// Drives directed and random command words and register writes into the
// monitor, while a separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module testbench
  import hbm_pkg::*;
();

  localparam int QuietLimit = 2000;
  localparam int DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  kind_i = KindTick;
  logic [15:0] module_id_i = 16'd0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CfgIdxEnable;
  logic [15:0] cfg_data_i = 16'd0;
  logic        busy_o;
  logic        valid_o;
  logic [2:0]  event_res_o;
  logic [15:0] module_id_out_o;
  logic [15:0] silence_ticks_o;
  logic        last_o;
  int unsigned fail_count;
  int unsigned pending_words;
  int          quiet_cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  heartbeat_timeout_monitor u_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .kind_i,
    .module_id_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .valid_o,
    .event_res_o,
    .module_id_out_o,
    .silence_ticks_o,
    .last_o
  );

  hbm_checker u_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i          (busy_o),
    .kind_i,
    .module_id_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .valid_i         (valid_o),
    .event_res_i     (event_res_o),
    .module_id_out_i (module_id_out_o),
    .silence_ticks_i (silence_ticks_o),
    .last_i          (last_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending_words)
  );

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_word(input logic [1:0] kind, input logic [15:0] id);
    start_i     <= 1'b1;
    kind_i      <= kind;
    module_id_i <= id;
    do begin
      @(posedge clk_i);
    end while (busy_o);
  endtask

  task automatic pause(input int cycles);
    start_i     <= 1'b0;
    kind_i      <= 2'($urandom);
    module_id_i <= 16'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic settle();
    start_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_words != 0 || busy_o);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(input int count, input int reg_pct, input int unreg_pct,
                           input int heard_pct);
    logic [15:0] id_pool[6];
    int          burst_left;
    int          roll;
    logic [1:0]  kind;
    logic [15:0] id;
    for (int j = 0; j < 6; j++) id_pool[j] = 16'($urandom);
    burst_left = $urandom_range(1, 12);
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < reg_pct) kind = KindRegister;
      else if (roll < reg_pct + unreg_pct) kind = KindUnreg;
      else if (roll < reg_pct + unreg_pct + heard_pct) kind = KindHeard;
      else kind = KindTick;
      if ($urandom_range(0, 99) < 85) id = id_pool[$urandom_range(0, 5)];
      else id = 16'($urandom);
      send_word(kind, id);
      burst_left--;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 15));
        burst_left = $urandom_range(1, 12);
      end
    end
    settle();
  endtask

  initial begin
    logic        en;
    logic [15:0] thr;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick on an empty table, then age two entries below a threshold they never reach.
    send_word(KindTick, 16'h0000);
    settle();
    write_reg(CfgIdxThreshold, 16'hFFFF);
    send_word(KindRegister, 16'hFFFF);
    send_word(KindRegister, 16'h0000);
    repeat (3) send_word(KindTick, 16'($urandom));
    send_word(KindUnreg, 16'h0000);
    settle();

    write_reg(CfgIdxThreshold, 16'h0001);
    send_word(KindHeard, 16'hFFFF);
    send_word(KindRegister, 16'h5A5A);
    send_word(KindRegister, 16'hFFFF);
    send_word(KindRegister, 16'hA5A5);
    send_word(KindHeard, 16'h1234);
    send_word(KindUnreg, 16'h1234);
    send_word(KindTick, 16'hFFFF);
    send_word(KindHeard, 16'hFFFF);
    send_word(KindTick, 16'h0000);
    settle();
    write_reg(CfgIdxThreshold, 16'h0000);
    send_word(KindTick, 16'h0000);
    settle();
    write_reg(CfgIdxEnable, 16'hFFFE);
    send_word(KindTick, 16'h0000);
    send_word(KindHeard, 16'h5A5A);
    settle();
    write_reg(CfgIdxEnable, 16'h0001);
    write_reg(CfgIdxThreshold, 16'h0001);

    // Duplicate removal, then fill the table until a register is refused.
    send_word(KindUnreg, 16'hFFFF);
    repeat (14) send_word(KindRegister, 16'($urandom));
    send_word(KindTick, 16'h0000);
    settle();

    for (int p = 0; p < 6; p++) begin
      en = 1'b1;
      case (p)
        0: thr = 16'($urandom_range(1, 4));
        1: thr = 16'($urandom_range(2, 12));
        2: begin
          en  = 1'b0;
          thr = 16'($urandom_range(1, 65535));
        end
        3: thr = 16'h0001;
        4: thr = 16'($urandom_range(3, 20));
        default: thr = 16'hFFFF;
      endcase
      write_reg(CfgIdxEnable, {15'($urandom), en});
      write_reg(CfgIdxThreshold, thr);
      case (p)
        0: run_phase(56, 40, 15, 15);
        1: run_phase(56, 25, 25, 20);
        2: run_phase(56, 30, 20, 20);
        3: run_phase(56, 35, 20, 15);
        4: run_phase(56, 20, 35, 15);
        default: run_phase(56, 30, 20, 20);
      endcase
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
